[hw/rtl/gmw_pkg.sv]
// shared types and constants of the grid maze walker
`default_nettype none
package gmw_pkg;

   localparam int STEP_W = 13;

   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   localparam logic [1:0] CELL_WALL = 2'd1;
   localparam logic [1:0] CELL_EXIT = 2'd2;

   localparam logic REPLY_WALK = 1'b0;
   localparam logic REPLY_READ = 1'b1;

   localparam logic [STEP_W-1:0] STEP_LIMIT = 13'd8191;

   localparam logic [1:0] CSR_ROW_COUNT   = 2'd0;
   localparam logic [1:0] CSR_COL_COUNT   = 2'd1;
   localparam logic [1:0] CSR_SEARCH_MODE = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [4:0] row;
      logic [4:0] col;
      logic [1:0] cell_type;
   } req_word_type;

   typedef struct packed {
      logic              reply_kind;
      logic              found;
      logic [STEP_W-1:0] step_value;
   } rsp_word_type;

   typedef struct packed {
      logic clear;
      logic push;
      logic pop;
      logic lifo;
   } frontier_ctl_type;

endpackage
`default_nettype wire

[hw/rtl/gmw_ram.sv]
// generic single write port ram with registered read
`default_nettype none
module gmw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

[hw/rtl/gmw_frontier.sv]
// frontier queue or stack with circular head pointer and entry count
`default_nettype none
module gmw_frontier #(
   parameter int DEPTH = 4096,
   parameter int DW    = 10
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire gmw_pkg::frontier_ctl_type ctl,
   input  wire logic [DW-1:0]             push_data,
   output logic                           empty,
   output logic [DW-1:0]                  pop_data
);

   localparam int FW = $clog2(DEPTH);

   logic [FW-1:0] head_ff, head_in;
   logic [FW:0]   count_ff, count_in;
   logic [FW:0]   tail_sum, top_sum;
   logic [FW-1:0] wr_addr, rd_addr;
   logic          full, wr_en;

   assign full  = (count_ff == (FW+1)'(DEPTH));
   assign empty = (count_ff == '0);
   assign wr_en = ctl.push && !full;

   always_comb begin
      tail_sum = {1'b0, head_ff} + count_ff;
      if (tail_sum >= (FW+1)'(DEPTH)) begin
         tail_sum = tail_sum - (FW+1)'(DEPTH);
      end
      wr_addr = tail_sum[FW-1:0];
      top_sum = {1'b0, head_ff} + count_ff - (FW+1)'(1);
      if (top_sum >= (FW+1)'(DEPTH)) begin
         top_sum = top_sum - (FW+1)'(DEPTH);
      end
      rd_addr = ctl.lifo ? top_sum[FW-1:0] : head_ff;
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (ctl.clear) begin
         head_in  = '0;
         count_in = '0;
      end else if (wr_en) begin
         count_in = count_ff + (FW+1)'(1);
      end else if (ctl.pop && !empty) begin
         count_in = count_ff - (FW+1)'(1);
         if (!ctl.lifo) begin
            head_in = ({1'b0, head_ff} + (FW+1)'(1) == (FW+1)'(DEPTH)) ? '0
                      : head_ff + FW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   gmw_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (push_data),
      .rd_addr (rd_addr),
      .rd_data (pop_data)
   );

endmodule
`default_nettype wire

[hw/rtl/grid_maze_bfs_dfs_walker.sv]
// grid maze walker top: csr, sequencer, grid, visit and frontier stores, result register
// a load is written as it is taken and leaves the input free; a read passes through the
// read and finish states, a walk clears the whole visit store, then checks each neighbor
// of a cell and pops the next from the frontier; both stall the input until the sequencer
// is idle, a stalled result holding it; reset: synchronous, a visit store sweep runs first
`default_nettype none
module grid_maze_bfs_dfs_walker #(
   parameter int MAX_ROWS       = 32,
   parameter int MAX_COLS       = 32,
   parameter int FRONTIER_DEPTH = 4096
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire gmw_pkg::req_word_type req_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output gmw_pkg::rsp_word_type      rsp_word,
   input  wire logic                  csr_wr_en,
   input  wire logic [1:0]            csr_index,
   input  wire logic [5:0]            csr_wdata
);

   localparam int RW = $clog2(MAX_ROWS);
   localparam int CW = $clog2(MAX_COLS);
   localparam int AW = RW + CW;
   localparam int SW = gmw_pkg::STEP_W;

   localparam logic [3:0] S_CLEAR   = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_READ    = 4'd2;
   localparam logic [3:0] S_INIT    = 4'd3;
   localparam logic [3:0] S_NBR     = 4'd4;
   localparam logic [3:0] S_NBR_CHK = 4'd5;
   localparam logic [3:0] S_TEST    = 4'd6;
   localparam logic [3:0] S_POP     = 4'd7;
   localparam logic [3:0] S_CUR_CHK = 4'd8;
   localparam logic [3:0] S_FIN     = 4'd9;

   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_RIGHT = 2'd1;
   localparam logic [1:0] DIR_DOWN  = 2'd2;
   localparam logic [1:0] DIR_LEFT  = 2'd3;

   // csr
   logic [5:0] row_count_ff, col_count_ff;
   logic       mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= 6'd32;
         col_count_ff <= 6'd32;
         mode_ff      <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            gmw_pkg::CSR_ROW_COUNT:   row_count_ff <= csr_wdata;
            gmw_pkg::CSR_COL_COUNT:   col_count_ff <= csr_wdata;
            gmw_pkg::CSR_SEARCH_MODE: mode_ff      <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic [8:0] rows, cols;

   always_comb begin
      if (row_count_ff == '0) begin
         rows = 9'd1;
      end else if (9'(row_count_ff) > 9'(MAX_ROWS)) begin
         rows = 9'(MAX_ROWS);
      end else begin
         rows = 9'(row_count_ff);
      end
      if (col_count_ff == '0) begin
         cols = 9'd1;
      end else if (9'(col_count_ff) > 9'(MAX_COLS)) begin
         cols = 9'(MAX_COLS);
      end else begin
         cols = 9'(col_count_ff);
      end
   end

   // sequencer state
   logic [3:0]    state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic          walk_clr_ff, walk_clr_in;
   logic [4:0]    start_r_ff, start_r_in, start_c_ff, start_c_in;
   logic [RW-1:0] cur_r_ff, cur_r_in, nb_r_ff, nb_r_in;
   logic [CW-1:0] cur_c_ff, cur_c_in, nb_c_ff, nb_c_in;
   logic [1:0]    dir_ff, dir_in;
   logic [SW-1:0] step_ff, step_in;
   logic          exit_ff, exit_in, first_ff, first_in, rd_ok_ff, rd_ok_in;
   gmw_pkg::rsp_word_type res_ff, res_in;

   // result register
   logic                  rsp_valid_ff;
   gmw_pkg::rsp_word_type rsp_word_ff;
   logic                  out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign req_stall = (state_ff != S_IDLE);

   // request decode
   logic [8:0]    req_r9, req_c9;
   logic          req_in_store, req_take;
   logic [AW-1:0] req_addr;

   assign req_r9       = 9'(req_word.row);
   assign req_c9       = 9'(req_word.col);
   assign req_in_store = (req_r9 < 9'(MAX_ROWS)) && (req_c9 < 9'(MAX_COLS));
   assign req_addr     = {req_r9[RW-1:0], req_c9[CW-1:0]};
   assign req_take     = req_valid && !req_stall;

   logic [8:0]    start_r9, start_c9;
   logic [AW-1:0] start_addr;

   assign start_r9   = 9'(start_r_ff);
   assign start_c9   = 9'(start_c_ff);
   assign start_addr = {start_r9[RW-1:0], start_c9[CW-1:0]};

   // neighbor of the current cell
   logic [8:0]    cr9, cc9, nr9, nc9;
   logic          nb_ok;
   logic [AW-1:0] nb_addr, nb_ff_addr;

   always_comb begin
      cr9   = 9'(cur_r_ff);
      cc9   = 9'(cur_c_ff);
      nr9   = cr9;
      nc9   = cc9;
      nb_ok = 1'b0;
      case (dir_ff)
         DIR_UP: begin
            nr9   = cr9 - 9'd1;
            nb_ok = (cr9 != '0);
         end
         DIR_RIGHT: begin
            nc9   = cc9 + 9'd1;
            nb_ok = (nc9 < cols);
         end
         DIR_DOWN: begin
            nr9   = cr9 + 9'd1;
            nb_ok = (nr9 < rows);
         end
         default: begin
            nc9   = cc9 - 9'd1;
            nb_ok = (cc9 != '0);
         end
      endcase
      nb_addr = {nr9[RW-1:0], nc9[CW-1:0]};
   end

   assign nb_ff_addr = {nb_r_ff, nb_c_ff};

   // store ports
   logic          grid_wr_en;
   logic [AW-1:0] grid_rd_addr;
   logic [1:0]    grid_rd_data;
   logic          visit_wr_en;
   logic [AW-1:0] visit_wr_addr, visit_rd_addr;
   logic [SW-1:0] visit_wr_data, visit_rd_data;
   gmw_pkg::frontier_ctl_type fr_ctl;
   logic          fr_empty;
   logic [AW-1:0] fr_pop_data;

   assign grid_wr_en = req_take && (req_word.kind == gmw_pkg::KIND_LOAD) && req_in_store;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      walk_clr_in   = walk_clr_ff;
      start_r_in    = start_r_ff;
      start_c_in    = start_c_ff;
      cur_r_in      = cur_r_ff;
      cur_c_in      = cur_c_ff;
      nb_r_in       = nb_r_ff;
      nb_c_in       = nb_c_ff;
      dir_in        = dir_ff;
      step_in       = step_ff;
      exit_in       = exit_ff;
      first_in      = first_ff;
      rd_ok_in      = rd_ok_ff;
      res_in        = res_ff;
      grid_rd_addr  = nb_addr;
      visit_rd_addr = nb_addr;
      visit_wr_en   = 1'b0;
      visit_wr_addr = clr_ff;
      visit_wr_data = '0;
      fr_ctl        = '{clear: 1'b0, push: 1'b0, pop: 1'b0, lifo: mode_ff};
      case (state_ff)
         S_CLEAR: begin
            visit_wr_en = 1'b1;
            clr_in      = clr_ff + AW'(1);
            if (clr_ff == '1) begin
               if (!walk_clr_ff) begin
                  state_in = S_IDLE;
               end else if (start_r9 >= rows || start_c9 >= cols) begin
                  res_in   = '{reply_kind: gmw_pkg::REPLY_WALK, found: 1'b0,
                               step_value: '0};
                  state_in = S_FIN;
               end else begin
                  state_in = S_INIT;
               end
            end
         end
         S_IDLE: begin
            visit_rd_addr = req_addr;
            if (req_take) begin
               case (req_word.kind)
                  gmw_pkg::KIND_START: begin
                     start_r_in  = req_word.row;
                     start_c_in  = req_word.col;
                     walk_clr_in = 1'b1;
                     clr_in      = '0;
                     state_in    = S_CLEAR;
                  end
                  gmw_pkg::KIND_READ: begin
                     rd_ok_in = req_in_store;
                     state_in = S_READ;
                  end
                  default: ;
               endcase
            end
         end
         S_READ: begin
            res_in   = '{reply_kind: gmw_pkg::REPLY_READ, found: 1'b0,
                         step_value: rd_ok_ff ? visit_rd_data : '0};
            state_in = S_FIN;
         end
         S_INIT: begin
            visit_wr_en   = 1'b1;
            visit_wr_addr = start_addr;
            visit_wr_data = SW'(1);
            grid_rd_addr  = start_addr;
            fr_ctl.clear  = 1'b1;
            cur_r_in      = start_r9[RW-1:0];
            cur_c_in      = start_c9[CW-1:0];
            step_in       = SW'(1);
            first_in      = 1'b1;
            state_in      = S_CUR_CHK;
         end
         S_NBR: begin
            nb_r_in = nr9[RW-1:0];
            nb_c_in = nc9[CW-1:0];
            if (nb_ok) begin
               state_in = S_NBR_CHK;
            end else if (dir_ff == DIR_LEFT) begin
               state_in = S_TEST;
            end else begin
               dir_in = dir_ff + 2'd1;
            end
         end
         S_NBR_CHK: begin
            fr_ctl.push = (visit_rd_data == '0) && (grid_rd_data != gmw_pkg::CELL_WALL);
            if (dir_ff == DIR_LEFT) begin
               state_in = S_TEST;
            end else begin
               dir_in   = dir_ff + 2'd1;
               state_in = S_NBR;
            end
         end
         S_TEST: begin
            if (fr_empty || step_ff >= gmw_pkg::STEP_LIMIT) begin
               res_in   = '{reply_kind: gmw_pkg::REPLY_WALK, found: exit_ff,
                            step_value: step_ff};
               state_in = S_FIN;
            end else begin
               fr_ctl.pop = 1'b1;
               state_in   = S_POP;
            end
         end
         S_POP: begin
            cur_r_in      = fr_pop_data[AW-1:CW];
            cur_c_in      = fr_pop_data[CW-1:0];
            step_in       = step_ff + SW'(1);
            visit_wr_en   = 1'b1;
            visit_wr_addr = fr_pop_data;
            visit_wr_data = step_ff + SW'(1);
            grid_rd_addr  = fr_pop_data;
            state_in      = S_CUR_CHK;
         end
         S_CUR_CHK: begin
            exit_in  = (grid_rd_data == gmw_pkg::CELL_EXIT);
            first_in = 1'b0;
            dir_in   = DIR_UP;
            if (!first_ff && grid_rd_data == gmw_pkg::CELL_EXIT) begin
               res_in   = '{reply_kind: gmw_pkg::REPLY_WALK, found: 1'b1,
                            step_value: step_ff};
               state_in = S_FIN;
            end else begin
               state_in = S_NBR;
            end
         end
         S_FIN: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         walk_clr_ff  <= 1'b0;
         dir_ff       <= DIR_UP;
         step_ff      <= '0;
         exit_ff      <= 1'b0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         walk_clr_ff <= walk_clr_in;
         dir_ff      <= dir_in;
         step_ff     <= step_in;
         exit_ff     <= exit_in;
         first_ff    <= first_in;
         if (state_ff == S_FIN && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      start_r_ff <= start_r_in;
      start_c_ff <= start_c_in;
      cur_r_ff   <= cur_r_in;
      cur_c_ff   <= cur_c_in;
      nb_r_ff    <= nb_r_in;
      nb_c_ff    <= nb_c_in;
      rd_ok_ff   <= rd_ok_in;
      res_ff     <= res_in;
      if (state_ff == S_FIN && out_free) begin
         rsp_word_ff <= res_ff;
      end
   end

   gmw_ram #(.WIDTH(2), .DEPTH(1 << AW)) u_grid (
      .clock   (clock),
      .wr_en   (grid_wr_en),
      .wr_addr (req_addr),
      .wr_data (req_word.cell_type),
      .rd_addr (grid_rd_addr),
      .rd_data (grid_rd_data)
   );

   gmw_ram #(.WIDTH(SW), .DEPTH(1 << AW)) u_visit (
      .clock   (clock),
      .wr_en   (visit_wr_en),
      .wr_addr (visit_wr_addr),
      .wr_data (visit_wr_data),
      .rd_addr (visit_rd_addr),
      .rd_data (visit_rd_data)
   );

   gmw_frontier #(.DEPTH(FRONTIER_DEPTH), .DW(AW)) u_frontier (
      .clock     (clock),
      .reset     (reset),
      .ctl       (fr_ctl),
      .push_data (nb_ff_addr),
      .empty     (fr_empty),
      .pop_data  (fr_pop_data)
   );

endmodule
`default_nettype wire

[test/grid_maze_bfs_dfs_walker_tb.sv]
// self-checking testbench of the grid maze walker: load, walk and read words against a predictor
`timescale 1ns / 1ps
module grid_maze_bfs_dfs_walker_tb;
   import gmw_pkg::*;

   localparam int GRID_ROWS = 32;
   localparam int GRID_COLS = 32;
   localparam int FRONT_DEPTH = 4096;
   localparam int CELLS = GRID_ROWS * GRID_COLS;
   localparam int FILL_SIDE = 16;
   localparam logic [1:0] KIND_NONE = 2'd3;
   localparam logic [1:0] CELL_OPEN = 2'd0;
   localparam logic [1:0] CELL_ODD = 2'd3;
   localparam int SETTLE_CYCLES = 16;
   localparam longint CYCLE_LIMIT = 40000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic csr_wr_en = 1'b0;
   logic [1:0] csr_index = '0;
   logic [5:0] csr_wdata = '0;

   grid_maze_bfs_dfs_walker dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // predictor state
   logic [1:0] maze_cell [CELLS];
   int visit_step [CELLS];
   int frontier [FRONT_DEPTH];
   int front_head, front_count, cur_cell, step_count;
   logic [5:0] rows_cfg = 6'd32;
   logic [5:0] cols_cfg = 6'd32;
   logic dfs_cfg = 1'b0;

   rsp_word_type pending_rsp [$];
   int fail_count = 0;
   int sent_count = 0;
   int walk_count = 0;
   int found_count = 0;
   int read_count = 0;
   longint cycle_count = 0;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int clamp_cnt(logic [5:0] v, int maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic req_word_type mk_word(logic [1:0] k, int r, int c, logic [1:0] t);
      req_word_type w;
      w.kind = k;
      w.row = r[4:0];
      w.col = c[4:0];
      w.cell_type = t;
      return w;
   endfunction

   function automatic void push_cell(int r, int c);
      int idx;
      idx = r * GRID_COLS + c;
      if (idx >= CELLS) return;
      if (visit_step[idx] != 0 || maze_cell[idx] == CELL_WALL) return;
      if (front_count >= FRONT_DEPTH) return;
      frontier[(front_head + front_count) % FRONT_DEPTH] = idx;
      front_count++;
   endfunction

   function automatic rsp_word_type walk_maze(int sr, int sc);
      int rows, cols, r, c;
      rsp_word_type res;
      rows = clamp_cnt(rows_cfg, GRID_ROWS);
      cols = clamp_cnt(cols_cfg, GRID_COLS);
      for (int i = 0; i < CELLS; i++) visit_step[i] = 0;
      front_head = 0;
      front_count = 0;
      res.reply_kind = REPLY_WALK;
      res.found = 1'b0;
      res.step_value = '0;
      if (sr >= rows || sc >= cols) begin
         cur_cell = 0;
         step_count = 0;
         return res;
      end
      cur_cell = sr * GRID_COLS + sc;
      step_count = 1;
      visit_step[cur_cell] = 1;
      forever begin
         r = cur_cell / GRID_COLS;
         c = cur_cell % GRID_COLS;
         if (r >= 1) push_cell(r - 1, c);
         if (c + 1 < cols) push_cell(r, c + 1);
         if (r + 1 < rows) push_cell(r + 1, c);
         if (c >= 1) push_cell(r, c - 1);
         if (front_count == 0 || step_count >= STEP_LIMIT) break;
         if (dfs_cfg) begin
            cur_cell = frontier[(front_head + front_count - 1) % FRONT_DEPTH];
         end else begin
            cur_cell = frontier[front_head];
            front_head = (front_head + 1) % FRONT_DEPTH;
         end
         front_count--;
         step_count++;
         visit_step[cur_cell] = step_count;
         if (maze_cell[cur_cell] == CELL_EXIT) break;
      end
      res.found = (maze_cell[cur_cell] == CELL_EXIT);
      res.step_value = step_count[STEP_W-1:0];
      return res;
   endfunction

   function automatic void predict_word(req_word_type w);
      rsp_word_type res;
      case (w.kind)
         KIND_LOAD: begin
            maze_cell[w.row * GRID_COLS + w.col] = w.cell_type;
         end
         KIND_START: begin
            res = walk_maze(w.row, w.col);
            walk_count++;
            if (res.found) found_count++;
            pending_rsp.push_back(res);
         end
         KIND_READ: begin
            res.reply_kind = REPLY_READ;
            res.found = 1'b0;
            res.step_value = visit_step[w.row * GRID_COLS + w.col][STEP_W-1:0];
            read_count++;
            pending_rsp.push_back(res);
         end
         default: ;
      endcase
   endfunction

   task automatic send_word(req_word_type w);
      int gap;
      req_word <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      predict_word(w);
      sent_count++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [5:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_ROW_COUNT: rows_cfg = val;
         CSR_COL_COUNT: cols_cfg = val;
         CSR_SEARCH_MODE: dfs_cfg = val[0];
         default: ;
      endcase
   endtask

   task automatic set_walk(logic [5:0] rws, logic [5:0] cls, logic mode);
      wait_quiet();
      write_csr(CSR_ROW_COUNT, rws);
      write_csr(CSR_COL_COUNT, cls);
      write_csr(CSR_SEARCH_MODE, {5'd0, mode});
   endtask

   function automatic logic [1:0] rand_cell();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return CELL_OPEN;
      if (r < 90) return CELL_WALL;
      if (r < 96) return CELL_EXIT;
      return CELL_ODD;
   endfunction

   // every cell a walk can reach is loaded first: the 16x16 corner, row 0 and column 0
   task automatic test_grid_fill();
      for (int i = 0; i < CELLS; i++)
         if (((i / GRID_COLS) < FILL_SIDE && (i % GRID_COLS) < FILL_SIDE) ||
             i < GRID_COLS || (i % GRID_COLS) == 0)
            send_word(mk_word(KIND_LOAD, i / GRID_COLS, i % GRID_COLS, rand_cell()));
   endtask

   task automatic test_directed();
      send_word(mk_word(KIND_READ, 31, 31, CELL_OPEN));
      set_walk(6'd16, 6'd16, 1'b0);
      send_word(mk_word(KIND_START, 0, 0, CELL_OPEN));
      send_word(mk_word(KIND_READ, 0, 0, CELL_OPEN));
      send_word(mk_word(KIND_READ, 31, 31, CELL_OPEN));
      send_word(mk_word(KIND_START, 15, 15, CELL_OPEN));
      set_walk(6'd2, 6'd2, 1'b1);
      send_word(mk_word(KIND_START, 5, 5, CELL_OPEN));
      send_word(mk_word(KIND_READ, 0, 0, CELL_OPEN));
      // enclosed exit start
      send_word(mk_word(KIND_LOAD, 0, 1, CELL_WALL));
      send_word(mk_word(KIND_LOAD, 1, 0, CELL_WALL));
      send_word(mk_word(KIND_LOAD, 0, 0, CELL_EXIT));
      send_word(mk_word(KIND_START, 0, 0, CELL_OPEN));
      send_word(mk_word(KIND_READ, 0, 0, CELL_OPEN));
      send_word(mk_word(KIND_NONE, 1, 1, CELL_EXIT));
      send_word(mk_word(KIND_LOAD, 1, 1, CELL_ODD));
      send_word(mk_word(KIND_LOAD, 1, 0, CELL_OPEN));
      send_word(mk_word(KIND_START, 1, 1, CELL_OPEN));
      send_word(mk_word(KIND_READ, 1, 0, CELL_OPEN));
      set_walk(6'd0, 6'd63, 1'b0);
      send_word(mk_word(KIND_START, 0, 31, CELL_OPEN));
      send_word(mk_word(KIND_READ, 0, 0, CELL_OPEN));
      set_walk(6'd63, 6'd1, 1'b1);
      send_word(mk_word(KIND_START, 31, 0, CELL_OPEN));
      send_word(mk_word(KIND_READ, 0, 0, CELL_OPEN));
   endtask

   task automatic test_random_phase(int n_items);
      int rows, cols, k;
      rows = clamp_cnt(rows_cfg, GRID_ROWS);
      cols = clamp_cnt(cols_cfg, GRID_COLS);
      for (int i = 0; i < n_items; i++) begin
         k = $urandom_range(0, 99);
         if (k < 8) begin
            if ($urandom_range(0, 9) == 0)
               send_word(mk_word(KIND_START, $urandom_range(0, 31), $urandom_range(0, 31),
                                 2'($urandom)));
            else
               send_word(mk_word(KIND_START, $urandom_range(0, rows - 1),
                                 $urandom_range(0, cols - 1), 2'($urandom)));
         end else if (k < 45) begin
            send_word(mk_word(KIND_LOAD, $urandom_range(0, rows - 1),
                              $urandom_range(0, cols - 1), rand_cell()));
         end else if (k < 50) begin
            send_word(mk_word(KIND_LOAD, $urandom_range(0, 31), $urandom_range(0, 31),
                              rand_cell()));
         end else if (k < 90) begin
            send_word(mk_word(KIND_READ, $urandom_range(0, rows - 1),
                              $urandom_range(0, cols - 1), 2'($urandom)));
         end else if (k < 96) begin
            send_word(mk_word(KIND_READ, $urandom_range(0, 31), $urandom_range(0, 31),
                              2'($urandom)));
         end else begin
            send_word(mk_word(KIND_NONE, $urandom_range(0, 31), $urandom_range(0, 31),
                              2'($urandom)));
         end
      end
   endtask

   task automatic test_random();
      for (int p = 0; p < 11; p++) begin
         case (p)
            0: set_walk(6'd16, 6'd16, 1'b0);
            1: set_walk(6'd16, 6'd16, 1'b1);
            2: set_walk(6'd1, 6'd1, 1'b0);
            3: set_walk(6'd63, 6'd0, 1'b1);
            default: set_walk(6'($urandom_range(1, 10)), 6'($urandom_range(1, 10)),
                              1'($urandom));
         endcase
         test_random_phase((p < 2) ? 40 : 85);
      end
   endtask

   // receiver stall pattern
   int stall_left = 0;
   int quiet_left = 0;
   always @(posedge clock) begin
      int r;
      if (quiet_left > 0) begin
         quiet_left--;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         r = $urandom_range(0, 99);
         rsp_stall <= 1'b0;
         if (r >= 60 && r < 90) stall_left = $urandom_range(1, 3);
         else if (r >= 90 && r < 97) quiet_left = $urandom_range(20, 80);
         else if (r >= 97) stall_left = $urandom_range(10, 40);
      end
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t unexpected rsp word %h", $time, rsp_word);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_word.reply_kind !== want.reply_kind) begin
               $display("%0t reply_kind expected %0d actual %0d", $time, want.reply_kind,
                        rsp_word.reply_kind);
               fail_count++;
            end
            if (rsp_word.found !== want.found) begin
               $display("%0t found expected %0d actual %0d", $time, want.found,
                        rsp_word.found);
               fail_count++;
            end
            if (rsp_word.step_value !== want.step_value) begin
               $display("%0t step_value expected %0d actual %0d", $time, want.step_value,
                        rsp_word.step_value);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < CELLS; i++) begin
         maze_cell[i] = CELL_OPEN;
         visit_step[i] = 0;
      end
      front_head = 0;
      front_count = 0;
      cur_cell = 0;
      step_count = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_grid_fill();
      test_directed();
      test_random();
      wait_quiet();
      repeat (40) @(posedge clock);
      $display("%0d words sent: %0d walks (%0d reached an exit), %0d step reads",
               sent_count, walk_count, found_count, read_count);
      $display("breadth-first and depth-first walks over count settings 0, 1, small, 16, 63");
      if (fail_count == 0 && pending_rsp.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches, %0d words still expected", fail_count, pending_rsp.size());
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
